### hdl/pipeline_hazard_stall_tracker_top_defines.svh
// Assertion macros for the hazard stall tracker.
// Used by pipeline_hazard_stall_tracker_top; expects clk and rst_n in scope.
`ifndef PIPELINE_HAZARD_STALL_TRACKER_TOP_DEFINES_SVH
`define PIPELINE_HAZARD_STALL_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, off while in reset
`define PHST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset
`define PHST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/phst_pkg.sv
// Shared types and constants for the hazard stall tracker.
// No dependencies; used by phst_cell and pipeline_hazard_stall_tracker_top.
package phst_pkg;

  // Pipeline geometry
  localparam int STAGES  = 8;
  localparam int ST_ID   = 2;
  localparam int ST_EXE1 = 3;
  localparam int ST_WB   = STAGES - 1;

  // Field widths
  localparam int ACT_W   = 2;
  localparam int TAG_W   = 5;
  localparam int FLUSH_W = 3;
  localparam int CNT_W   = 32;
  localparam int ADD_W   = 4;
  localparam int REM_W   = 3;

  // Cycle counter starts at the pipeline fill cost
  localparam logic [CNT_W-1:0] CYCLE_RESET = CNT_W'(STAGES - 1);

  // Action codes
  localparam logic [ACT_W-1:0] ACT_CLOCK = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SRC   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEST  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd3;

  // Per-cell control
  typedef struct packed {
    logic load;   // write tag from the decode port
    logic shift;  // take neighbor's entry
    logic clear;  // become empty
  } cell_ctrl_t;

endpackage

### hdl/pipeline_hazard_stall_tracker_top.sv
// RAW hazard interlock tracker for an 8-stage pipeline (IF1..WB), built as a
// row of eight tag cells with a small sequencer. Clock ticks, destination
// writes and source reads that hit nothing need no busy state. A source read
// that hits a producer inserts 1 to 5 bubbles, one per shift, since the cells
// shift once per cycle; a flush of N (up to 7) advances the cells N times. One
// result word leaves per input word through an output register, so a finished
// result can wait for out_ready while the next input word is already being
// worked on.
module pipeline_hazard_stall_tracker_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [phst_pkg::ACT_W-1:0]   in_action,
  input  logic [phst_pkg::TAG_W-1:0]   in_reg_index,
  input  logic [phst_pkg::FLUSH_W-1:0] in_flush_ops,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [phst_pkg::CNT_W-1:0]   out_cycle_total,
  output logic [phst_pkg::CNT_W-1:0]   out_bubble_total,
  output logic [phst_pkg::CNT_W-1:0]   out_flush_total,
  output logic [phst_pkg::ADD_W-1:0]   out_bubbles_added
);
  import phst_pkg::*;
  `include "pipeline_hazard_stall_tracker_top_defines.svh"

  // sequencer state codes
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FLUSH  = 2'd1;
  localparam logic [1:0] S_BUBBLE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [REM_W-1:0] cnt_r, cnt_nxt;
  logic [ADD_W-1:0] added_r, added_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] cycle_cnt_r, cycle_cnt_nxt;
  logic [CNT_W-1:0] bubble_cnt_r, bubble_cnt_nxt;
  logic [CNT_W-1:0] flush_cnt_r, flush_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] out_cycle_r, out_bubble_r, out_flush_r;
  logic [ADD_W-1:0] out_added_r;

  logic             accept, slot_free, drain, done;
  logic             op_adv, op_bub, op_flush, op_load;
  logic             hit;
  logic [REM_W-1:0] hit_dist;

  logic             stg_valid [STAGES];
  logic [TAG_W-1:0] stg_tag   [STAGES];
  logic             stg_match [STAGES];
  logic             up_valid  [STAGES];
  logic [TAG_W-1:0] up_tag    [STAGES];
  cell_ctrl_t       cell_ctrl [STAGES];

  // handshake
  assign slot_free = !out_valid_r || out_ready;
  assign drain     = pend_r && slot_free;
  assign in_ready  = (state_r == S_IDLE) && (!pend_r || slot_free);
  assign accept    = in_valid && in_ready;

  // cell chain
  assign up_valid[0] = 1'b0;
  assign up_tag[0]   = '0;
  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign up_valid[i] = stg_valid[i-1];
      assign up_tag[i]   = stg_tag[i-1];
    end
    assign cell_ctrl[i].load  = op_load && (i == ST_ID);
    assign cell_ctrl[i].shift = op_adv || (op_bub && (i > ST_EXE1));
    assign cell_ctrl[i].clear = op_bub && (i == ST_EXE1);

    phst_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl[i]),
      .up_valid (up_valid[i]),
      .up_tag   (up_tag[i]),
      .load_tag (in_reg_index),
      .cmp_tag  (in_reg_index),
      .valid    (stg_valid[i]),
      .tag      (stg_tag[i]),
      .match    (stg_match[i])
    );
  end

  // first producer from ID toward MEM2; later stages only hold entries
  // already passed over, so the first hit sets the whole stall
  always_comb begin
    hit      = 1'b0;
    hit_dist = '0;
    for (int s = ST_WB - 1; s >= ST_ID; s--) begin
      if (stg_match[s] && (in_reg_index != '0)) begin
        hit      = 1'b1;
        hit_dist = REM_W'(ST_WB - s);
      end
    end
  end

  // sequencer: one pipeline operation per cycle
  always_comb begin
    op_adv    = 1'b0;
    op_bub    = 1'b0;
    op_flush  = 1'b0;
    op_load   = 1'b0;
    done      = 1'b0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    added_nxt = added_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          added_nxt = '0;
          case (in_action)
            ACT_CLOCK: begin
              op_adv = 1'b1;
              done   = 1'b1;
            end
            ACT_DEST: begin
              op_load = 1'b1;
              done    = 1'b1;
            end
            ACT_SRC: begin
              added_nxt = ADD_W'(hit_dist);
              if (hit) begin
                op_bub = 1'b1;
                if (hit_dist == REM_W'(1)) begin
                  done = 1'b1;
                end else begin
                  state_nxt = S_BUBBLE;
                  cnt_nxt   = hit_dist - REM_W'(1);
                end
              end else begin
                done = 1'b1;
              end
            end
            ACT_FLUSH: begin
              if (in_flush_ops == '0) begin
                done = 1'b1;
              end else begin
                op_adv   = 1'b1;
                op_flush = 1'b1;
                if (in_flush_ops == FLUSH_W'(1)) begin
                  done = 1'b1;
                end else begin
                  state_nxt = S_FLUSH;
                  cnt_nxt   = REM_W'(in_flush_ops - FLUSH_W'(1));
                end
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_FLUSH: begin
        op_adv   = 1'b1;
        op_flush = 1'b1;
        cnt_nxt  = cnt_r - REM_W'(1);
        if (cnt_r == REM_W'(1)) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_BUBBLE: begin
        op_bub  = 1'b1;
        cnt_nxt = cnt_r - REM_W'(1);
        if (cnt_r == REM_W'(1)) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // running counters
  assign cycle_cnt_nxt  = cycle_cnt_r + {{(CNT_W-1){1'b0}}, op_adv || op_bub};
  assign bubble_cnt_nxt = bubble_cnt_r + {{(CNT_W-1){1'b0}}, op_bub};
  assign flush_cnt_nxt  = flush_cnt_r + {{(CNT_W-1){1'b0}}, op_flush};

  // result pending until the output register can take it
  assign pend_nxt      = done ? 1'b1 : (drain ? 1'b0 : pend_r);
  assign out_valid_nxt = drain ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      cycle_cnt_r  <= CYCLE_RESET;
      bubble_cnt_r <= '0;
      flush_cnt_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
      cycle_cnt_r  <= cycle_cnt_nxt;
      bubble_cnt_r <= bubble_cnt_nxt;
      flush_cnt_r  <= flush_cnt_nxt;
    end
  end

  // output word, loaded from the settled counters
  always_ff @(posedge clk) begin
    added_r <= added_nxt;
    if (drain) begin
      out_cycle_r  <= cycle_cnt_r;
      out_bubble_r <= bubble_cnt_r;
      out_flush_r  <= flush_cnt_r;
      out_added_r  <= added_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cycle_total   = out_cycle_r;
  assign out_bubble_total  = out_bubble_r;
  assign out_flush_total   = out_flush_r;
  assign out_bubbles_added = out_added_r;

  // checks
  `PHST_ASSERT_NOW(a_busy_has_work, state_r != S_IDLE, cnt_r != '0, "busy with no work left")
  `PHST_ASSERT_NOW(a_busy_blocks_in, state_r != S_IDLE, !in_ready, "input taken while busy")
  `PHST_ASSERT_NEXT(a_bubble_count, op_bub,
                    bubble_cnt_r == $past(bubble_cnt_r) + 32'd1, "bubble not counted")
  `PHST_ASSERT_NEXT(a_exe1_empty, op_bub, !stg_valid[ST_EXE1], "EXE1 not empty after bubble")

endmodule

### hdl/phst_cell.sv
// One pipeline stage cell: holds a valid bit and a register tag.
// Depends on phst_pkg.
module phst_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  phst_pkg::cell_ctrl_t      ctrl,
  input  logic                      up_valid,
  input  logic [phst_pkg::TAG_W-1:0] up_tag,
  input  logic [phst_pkg::TAG_W-1:0] load_tag,
  input  logic [phst_pkg::TAG_W-1:0] cmp_tag,
  output logic                      valid,
  output logic [phst_pkg::TAG_W-1:0] tag,
  output logic                      match
);
  import phst_pkg::*;

  logic             valid_r, valid_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;

  // next entry: load, take from upstream, or empty
  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    if (ctrl.load) begin
      valid_nxt = 1'b1;
      tag_nxt   = load_tag;
    end else if (ctrl.shift) begin
      valid_nxt = up_valid;
      tag_nxt   = up_tag;
    end else if (ctrl.clear) begin
      valid_nxt = 1'b0;
      tag_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // tag is payload, no reset
  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

  assign valid = valid_r;
  assign tag   = tag_r;
  assign match = valid_r && (tag_r == cmp_tag);

endmodule
